// ===== sv/bsort_pkg.sv =====
// Shared constants for the length-checked byte sorter.
// No dependencies; used by byte_sort_with_length_check.
package bsort_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 6;
	localparam int STATUS_W    = 2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEWER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MORE  = 2'd2;

endpackage

// ===== sv/bsort_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsort_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/byte_sort_with_length_check.sv =====
// Length-checked byte sorter: one character beat per cycle while loading with the output
// free, then an in-RAM bubble sort with a single comparator (n-1 passes), then a drain
// that reads each sorted character into the output register, waiting while the output is
// held. A length mismatch gives one status beat on the cycle after the last input beat.
// Input is not ready while sorting or draining. Asynchronous active-low reset clears count,
// overflow flag, sequencer, output valid and the length register; the RAM holds no reset.
module byte_sort_with_length_check #(
	parameter int MAX_LEN = bsort_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] char_in
	input  logic                          s_tlast,   // is_last
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] char_out
	output logic [bsort_pkg::STATUS_W-1:0] m_tuser,  // [1:0] status
	output logic                          m_tlast,   // last_out
	// length register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsort_pkg::LEN_W-1:0]   cfg_data   // [5:0] expected_length
);

	localparam int AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW   = $clog2(MAX_LEN + 1);
	localparam int CMPW = (CW > bsort_pkg::LEN_W) ? CW + 1 : bsort_pkg::LEN_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_DRD  = 3'd4;
	localparam logic [2:0] S_DLD  = 3'd5;

	logic [2:0]                       state_q;
	logic [CW-1:0]                    count_q;
	logic                             ovf_q;
	logic [bsort_pkg::LEN_W-1:0]      exp_len_q;
	logic [AW-1:0]                    nm1_q;
	logic [AW-1:0]                    lim_q;
	logic [AW-1:0]                    idx_q;
	logic [bsort_pkg::CHAR_W-1:0]     carry_q;

	logic                             out_valid_q;
	logic [bsort_pkg::CHAR_W-1:0]     out_char_q;
	logic [bsort_pkg::STATUS_W-1:0]   out_status_q;
	logic                             out_last_q;

	logic                             in_acc;
	logic                             full;
	logic [CMPW-1:0]                  n_new;
	logic [CMPW-1:0]                  exp_ext;
	logic [AW-1:0]                    nm1_new;
	logic                             err_more;
	logic                             err_fewer;
	logic                             out_free;
	logic                             swap;

	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [bsort_pkg::CHAR_W-1:0]     ram_wdata;
	logic                             ram_re;
	logic [AW-1:0]                    ram_raddr;
	logic [bsort_pkg::CHAR_W-1:0]     ram_rdata;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign full    = (count_q == CW'(MAX_LEN));
	assign n_new   = full ? CMPW'(count_q) : CMPW'(count_q) + CMPW'(1);
	assign exp_ext = CMPW'(exp_len_q);
	assign nm1_new = full ? AW'(MAX_LEN - 1) : count_q[AW-1:0];
	assign err_more  = ovf_q || full || (n_new > exp_ext);
	assign err_fewer = (n_new < exp_ext);

	// the one comparator: running maximum of the pass against the fetched byte
	assign swap = (carry_q > ram_rdata);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = s_tdata;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				ram_we = in_acc && !full;
			end
			S_RD, S_DRD: begin
				ram_re = 1'b1;
			end
			S_CMP: begin
				ram_we    = (idx_q != '0);
				ram_waddr = idx_q - AW'(1);
				ram_wdata = swap ? ram_rdata : carry_q;
			end
			S_FIN: begin
				ram_we    = 1'b1;
				ram_waddr = lim_q;
				ram_wdata = carry_q;
			end
			default: begin
			end
		endcase
	end

	bsort_ram #(
		.WIDTH(bsort_pkg::CHAR_W),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			exp_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (s_tlast) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							if (err_more || err_fewer) begin
								out_valid_q <= 1'b1;
							end else if (nm1_new == '0) begin
								state_q <= S_DRD;
							end else begin
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (idx_q == '0) begin
						state_q <= S_RD;
					end else if (idx_q == lim_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					state_q <= S_RD;
					if (lim_q == AW'(1)) begin
						state_q <= S_DRD;
					end
				end
				S_DRD: begin
					state_q <= S_DLD;
				end
				S_DLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= (idx_q == nm1_q) ? S_IDLE : S_DRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && s_tlast) begin
					nm1_q <= nm1_new;
					lim_q <= nm1_new;
					idx_q <= '0;
					if (err_more || err_fewer) begin
						out_char_q   <= '0;
						out_status_q <= err_more ? bsort_pkg::ST_MORE : bsort_pkg::ST_FEWER;
						out_last_q   <= 1'b1;
					end
				end
			end
			S_CMP: begin
				if (idx_q == '0) begin
					carry_q <= ram_rdata;
					idx_q   <= AW'(1);
				end else begin
					if (!swap) begin
						carry_q <= ram_rdata;
					end
					idx_q <= idx_q + AW'(1);
				end
			end
			S_FIN: begin
				idx_q <= '0;
				if (lim_q != AW'(1)) begin
					lim_q <= lim_q - AW'(1);
				end
			end
			S_DLD: begin
				if (out_free) begin
					out_char_q   <= ram_rdata;
					out_status_q <= bsort_pkg::ST_OK;
					out_last_q   <= (idx_q == nm1_q);
					idx_q        <= idx_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	a_err_beat_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != bsort_pkg::ST_OK) |-> (m_tlast && m_tdata == '0))
		else $error("status beat without last flag or with nonzero character");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LEN))
		else $error("character count above store depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full)
		else $error("overflow flag set with store not full");

	// compare steps walk 0..lim; the write-back step sees the index one past
	a_pass_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (idx_q <= lim_q && lim_q <= nm1_q))
		else $error("sort index beyond pass limit");

	a_idle_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !s_tlast) |=> (state_q == S_IDLE))
		else $error("sequencer left idle on a non-final beat");

endmodule
